// ===== sv/rpn_pkg.sv =====
// Package for the RPN stack calculator: token and error codes, sequencer
// states, the divider control group and Q16.16 limits. No dependencies.
package rpn_pkg;

    localparam int DATA_W = 32;
    localparam int DIV_W  = 48;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        MODE_NUM    = 4'd0,
        MODE_ADD    = 4'd1,
        MODE_SUB    = 4'd2,
        MODE_MUL    = 4'd3,
        MODE_DIV    = 4'd4,
        MODE_MOD    = 4'd5,
        MODE_PEEK   = 4'd6,
        MODE_DUP    = 4'd7,
        MODE_SWAP   = 4'd8,
        MODE_CLEAR  = 4'd9,
        MODE_VAR    = 4'd10,
        MODE_ASSIGN = 4'd11,
        MODE_LAST   = 4'd12,
        MODE_EOL    = 4'd13
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_EMPTY   = 3'd1,
        ERR_FULL    = 3'd2,
        ERR_SWAP    = 3'd3,
        ERR_NOT_VAR = 3'd4,
        ERR_DIV0    = 3'd5
    } err_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_TOP,
        S_RD_SEC,
        S_CAPTURE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIV_FIN,
        S_WRITE,
        S_SWAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctl_t;

endpackage

// ===== sv/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/rpn_div.sv =====
// Radix-2 restoring divider for Q16.16 divide and remainder, one quotient
// bit per cycle for a 48-bit quotient. Depends on rpn_pkg.
module rpn_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpn_pkg::div_ctl_t                   ctl,
    input  logic signed [rpn_pkg::DATA_W-1:0]   num_a,
    input  logic signed [rpn_pkg::DATA_W-1:0]   num_b,
    output logic                                done,
    output logic [rpn_pkg::DIV_W-1:0]           quotient,
    output logic [rpn_pkg::DATA_W-1:0]          remainder
);

    localparam int CW = $clog2(rpn_pkg::DIV_W);
    localparam logic [CW-1:0] CNT_LAST = CW'(rpn_pkg::DIV_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CW-1:0]                cnt_reg;
    logic [rpn_pkg::DIV_W-1:0]    dvd_reg;
    logic [rpn_pkg::DATA_W-1:0]   dvs_reg;
    logic [rpn_pkg::DATA_W-1:0]   rem_reg;

    logic [rpn_pkg::DATA_W-1:0]   abs_a;
    logic [rpn_pkg::DATA_W-1:0]   abs_b;
    logic [rpn_pkg::DATA_W:0]     rem_sh;
    logic [rpn_pkg::DATA_W:0]     rem_sub;
    logic                         q_bit;
    logic [rpn_pkg::DATA_W-1:0]   rem_next;

    always_comb
    begin
        abs_a    = num_a[rpn_pkg::DATA_W-1] ? 32'(-num_a) : 32'(num_a);
        abs_b    = num_b[rpn_pkg::DATA_W-1] ? 32'(-num_b) : 32'(num_b);
        rem_sh   = {rem_reg, dvd_reg[rpn_pkg::DIV_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_next = q_bit ? rem_sub[rpn_pkg::DATA_W-1:0] : rem_sh[rpn_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            dvd_reg <= ctl.is_mod ? {16'd0, abs_a} : {abs_a, 16'd0};
            dvs_reg <= abs_b;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[rpn_pkg::DIV_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// Reverse Polish stack calculator on signed Q16.16, one token per item.
// Multiply, swap, and divide and remainder with a nonzero divisor (48-step shared
// divider) pass through extra states; the next item is taken only after the result
// of the last one is issued, and any output stall holds it back.
// The stack sits in a registered-read RAM read twice per token.
// Reset (rst_n, async, active low) empties the stack and clears variables,
// the last printed value and the sequencer; stack RAM contents are undefined.
// Depends on rpn_pkg, rpn_ram and rpn_div.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH   = 128,
    parameter int NUM_VARIABLES = 26
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // number_value[31:0], var_index[36:32], zero fill
    input  logic [3:0]  s_tuser,   // mode[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // print_value[31:0], error_code[34:32],
                                   // stack_depth[42:35], zero fill
    output logic [0:0]  m_tuser    // printed
);

    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int VW  = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
    localparam logic [SPW-1:0] DEPTH_C = SPW'(STACK_DEPTH);
    localparam logic [4:0]     NVAR_C  = 5'(NUM_VARIABLES);

    rpn_pkg::state_t          state_reg, state_next;
    rpn_pkg::mode_t           mode_reg, mode_next;
    logic signed [31:0]       num_reg, num_next;
    logic [4:0]               vidx_reg, vidx_next;
    logic [SPW-1:0]           sp_reg, sp_next;
    logic signed [31:0]       top_reg, top_next;
    logic signed [31:0]       sec_reg, sec_next;
    logic signed [31:0]       res_reg, res_next;
    logic                     wr_flag_reg, wr_flag_next;
    logic [AW-1:0]            wr_addr_reg, wr_addr_next;
    rpn_pkg::err_t            err_reg, err_next;
    logic                     printed_reg, printed_next;
    logic signed [31:0]       pval_reg, pval_next;
    logic signed [31:0]       last_reg, last_next;
    logic                     prev_var_reg, prev_var_next;
    logic [4:0]               prev_idx_reg, prev_idx_next;
    logic                     qneg_reg, qneg_next;
    logic                     aneg_reg, aneg_next;
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [31:0]       var_reg [NUM_VARIABLES];
    logic                     var_we;
    logic [VW-1:0]            var_waddr;
    logic signed [31:0]       var_wdata;
    logic                     m_tvalid_reg;
    logic [47:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     has1, has2, full, vidx_ok, div_zero;
    logic signed [31:0]       opa, opb;
    logic [AW-1:0]            top_addr, sec_addr, push_addr;
    logic [SPW-1:0]           pop2_sp, pop1_sp;
    rpn_pkg::err_t            pop_err;
    logic signed [32:0]       sum_w;
    logic signed [47:0]       mul_sh;
    logic [47:0]              quo;
    logic [31:0]              rem;
    logic signed [31:0]       sum_sat, div_res, mod_res, mul_res;
    logic                     is_div_op, out_free;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [31:0]              ram_wdata, ram_rdata;
    rpn_pkg::div_ctl_t        div_ctl;
    logic                     div_done;

    rpn_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .num_a     (opa),
        .num_b     (opb),
        .done      (div_done),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        has1      = (sp_reg != '0);
        has2      = (sp_reg >= SPW'(2));
        full      = (sp_reg >= DEPTH_C);
        vidx_ok   = (vidx_reg < NVAR_C);
        opb       = has1 ? top_reg : 32'sd0;
        opa       = has2 ? sec_reg : 32'sd0;
        div_zero  = (opb == 32'sd0);
        top_addr  = has1 ? AW'(sp_reg - SPW'(1)) : '0;
        sec_addr  = has2 ? AW'(sp_reg - SPW'(2)) : '0;
        push_addr = AW'(sp_reg);
        pop2_sp   = has2 ? sp_reg - SPW'(2) : '0;
        pop1_sp   = has1 ? sp_reg - SPW'(1) : '0;
        pop_err   = has2 ? rpn_pkg::ERR_NONE : rpn_pkg::ERR_EMPTY;
        is_div_op = (mode_reg == rpn_pkg::MODE_DIV) || (mode_reg == rpn_pkg::MODE_MOD);
        out_free  = !m_tvalid_reg || m_tready;

        sum_w = (mode_reg == rpn_pkg::MODE_SUB) ? 33'(opa) - 33'(opb)
                                                : 33'(opa) + 33'(opb);
        if (sum_w[32] != sum_w[31])
        begin
            sum_sat = sum_w[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
        end
        else
        begin
            sum_sat = sum_w[31:0];
        end

        mul_sh = prod_reg[63:16];
        if (!(&mul_sh[47:31]) && (|mul_sh[47:31]))
        begin
            mul_res = mul_sh[47] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
        end
        else
        begin
            mul_res = mul_sh[31:0];
        end

        if (!qneg_reg)
        begin
            div_res = (quo[47:31] != '0) ? rpn_pkg::Q_MAX : $signed(quo[31:0]);
        end
        else if ((quo[47:32] != '0) || (quo[31] && (quo[30:0] != '0)))
        begin
            div_res = rpn_pkg::Q_MIN;
        end
        else
        begin
            div_res = -$signed(quo[31:0]);
        end
        mod_res = aneg_reg ? -$signed(rem) : $signed(rem);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rpn_pkg::S_RD_TOP;
                end
            end
            rpn_pkg::S_RD_TOP:  state_next = rpn_pkg::S_RD_SEC;
            rpn_pkg::S_RD_SEC:  state_next = rpn_pkg::S_CAPTURE;
            rpn_pkg::S_CAPTURE: state_next = rpn_pkg::S_EXEC;
            rpn_pkg::S_EXEC:
            begin
                if (mode_reg == rpn_pkg::MODE_MUL)
                begin
                    state_next = rpn_pkg::S_MUL;
                end
                else if (is_div_op && !div_zero)
                begin
                    state_next = rpn_pkg::S_DIV;
                end
                else
                begin
                    state_next = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_MUL: state_next = rpn_pkg::S_WRITE;
            rpn_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = rpn_pkg::S_DIV_FIN;
                end
            end
            rpn_pkg::S_DIV_FIN: state_next = rpn_pkg::S_WRITE;
            rpn_pkg::S_WRITE:
            begin
                if ((mode_reg == rpn_pkg::MODE_SWAP) && wr_flag_reg)
                begin
                    state_next = rpn_pkg::S_SWAP;
                end
                else
                begin
                    state_next = rpn_pkg::S_DONE;
                end
            end
            rpn_pkg::S_SWAP: state_next = rpn_pkg::S_DONE;
            rpn_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = rpn_pkg::S_IDLE;
                end
            end
            default: state_next = rpn_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == rpn_pkg::S_IDLE);
        ram_raddr     = (state_reg == rpn_pkg::S_RD_TOP) ? top_addr : sec_addr;
        ram_we        = ((state_reg == rpn_pkg::S_WRITE) && wr_flag_reg)
                        || (state_reg == rpn_pkg::S_SWAP);
        ram_waddr     = (state_reg == rpn_pkg::S_SWAP) ? sec_addr : wr_addr_reg;
        ram_wdata     = (state_reg == rpn_pkg::S_SWAP) ? top_reg : res_reg;
        div_ctl.start = (state_reg == rpn_pkg::S_EXEC) && is_div_op && !div_zero;
        div_ctl.is_mod = (mode_reg == rpn_pkg::MODE_MOD);

        mode_next     = mode_reg;
        num_next      = num_reg;
        vidx_next     = vidx_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        sec_next      = sec_reg;
        res_next      = res_reg;
        wr_flag_next  = wr_flag_reg;
        wr_addr_next  = wr_addr_reg;
        err_next      = err_reg;
        printed_next  = printed_reg;
        pval_next     = pval_reg;
        last_next     = last_reg;
        prev_var_next = prev_var_reg;
        prev_idx_next = prev_idx_reg;
        qneg_next     = qneg_reg;
        aneg_next     = aneg_reg;
        prod_next     = prod_reg;
        var_we        = 1'b0;
        var_waddr     = prev_idx_reg[VW-1:0];
        var_wdata     = opa;

        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next = rpn_pkg::mode_t'(s_tuser);
                    num_next  = s_tdata[31:0];
                    vidx_next = s_tdata[36:32];
                end
            end
            rpn_pkg::S_RD_SEC:  top_next = ram_rdata;
            rpn_pkg::S_CAPTURE: sec_next = ram_rdata;
            rpn_pkg::S_EXEC:
            begin
                err_next      = rpn_pkg::ERR_NONE;
                printed_next  = 1'b0;
                pval_next     = 32'sd0;
                wr_flag_next  = 1'b0;
                wr_addr_next  = push_addr;
                prev_var_next = 1'b0;
                prev_idx_next = vidx_reg;
                qneg_next     = opa[31] ^ opb[31];
                aneg_next     = opa[31];
                prod_next     = 64'(opa) * 64'(opb);
                case (mode_reg)
                    rpn_pkg::MODE_NUM, rpn_pkg::MODE_LAST:
                    begin
                        if (full)
                        begin
                            err_next = rpn_pkg::ERR_FULL;
                        end
                        else
                        begin
                            res_next     = (mode_reg == rpn_pkg::MODE_NUM) ? num_reg : last_reg;
                            wr_flag_next = 1'b1;
                            sp_next      = sp_reg + SPW'(1);
                        end
                    end
                    rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL,
                    rpn_pkg::MODE_DIV, rpn_pkg::MODE_MOD:
                    begin
                        err_next     = pop_err;
                        wr_flag_next = 1'b1;
                        wr_addr_next = AW'(pop2_sp);
                        sp_next      = pop2_sp + SPW'(1);
                        res_next     = sum_sat;
                        if (is_div_op && div_zero)
                        begin
                            err_next = rpn_pkg::ERR_DIV0;
                            if (pop_err != rpn_pkg::ERR_NONE)
                            begin
                                err_next = pop_err;
                            end
                            if (mode_reg == rpn_pkg::MODE_MOD)
                            begin
                                res_next = opa;
                            end
                            else if (opa > 32'sd0)
                            begin
                                res_next = rpn_pkg::Q_MAX;
                            end
                            else if (opa < 32'sd0)
                            begin
                                res_next = rpn_pkg::Q_MIN;
                            end
                            else
                            begin
                                res_next = 32'sd0;
                            end
                        end
                    end
                    rpn_pkg::MODE_PEEK:
                    begin
                        err_next     = has1 ? rpn_pkg::ERR_NONE : rpn_pkg::ERR_EMPTY;
                        printed_next = 1'b1;
                        pval_next    = opb;
                        last_next    = opb;
                    end
                    rpn_pkg::MODE_DUP:
                    begin
                        if (!has1)
                        begin
                            err_next = rpn_pkg::ERR_EMPTY;
                        end
                        else if (full)
                        begin
                            err_next = rpn_pkg::ERR_FULL;
                        end
                        else
                        begin
                            res_next     = top_reg;
                            wr_flag_next = 1'b1;
                            sp_next      = sp_reg + SPW'(1);
                        end
                    end
                    rpn_pkg::MODE_SWAP:
                    begin
                        if (!has2)
                        begin
                            err_next = rpn_pkg::ERR_SWAP;
                        end
                        else
                        begin
                            res_next     = sec_reg;
                            wr_flag_next = 1'b1;
                            wr_addr_next = top_addr;
                        end
                    end
                    rpn_pkg::MODE_CLEAR: sp_next = '0;
                    rpn_pkg::MODE_VAR:
                    begin
                        if (!vidx_ok)
                        begin
                            err_next = rpn_pkg::ERR_NOT_VAR;
                        end
                        else
                        begin
                            prev_var_next = 1'b1;
                            if (full)
                            begin
                                err_next = rpn_pkg::ERR_FULL;
                            end
                            else
                            begin
                                res_next     = var_reg[vidx_reg[VW-1:0]];
                                wr_flag_next = 1'b1;
                                sp_next      = sp_reg + SPW'(1);
                            end
                        end
                    end
                    rpn_pkg::MODE_ASSIGN:
                    begin
                        if (prev_var_reg)
                        begin
                            err_next = pop_err;
                            sp_next  = pop2_sp;
                            var_we   = 1'b1;
                        end
                        else
                        begin
                            err_next = has1 ? rpn_pkg::ERR_NOT_VAR : rpn_pkg::ERR_EMPTY;
                            sp_next  = pop1_sp;
                        end
                    end
                    rpn_pkg::MODE_EOL:
                    begin
                        err_next     = has1 ? rpn_pkg::ERR_NONE : rpn_pkg::ERR_EMPTY;
                        printed_next = 1'b1;
                        pval_next    = opb;
                        last_next    = opb;
                        sp_next      = pop1_sp;
                    end
                    default: err_next = rpn_pkg::ERR_NOT_VAR;
                endcase
            end
            rpn_pkg::S_MUL: res_next = mul_res;
            rpn_pkg::S_DIV_FIN:
            begin
                res_next = (mode_reg == rpn_pkg::MODE_MOD) ? mod_res : div_res;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rpn_pkg::S_IDLE;
            sp_reg       <= '0;
            last_reg     <= '0;
            prev_var_reg <= 1'b0;
            prev_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_VARIABLES; i++)
            begin
                var_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            last_reg     <= last_next;
            prev_var_reg <= prev_var_next;
            prev_idx_reg <= prev_idx_next;
            if (var_we)
            begin
                var_reg[var_waddr] <= var_wdata;
            end
            if ((state_reg == rpn_pkg::S_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        num_reg     <= num_next;
        vidx_reg    <= vidx_next;
        top_reg     <= top_next;
        sec_reg     <= sec_next;
        res_reg     <= res_next;
        wr_flag_reg <= wr_flag_next;
        wr_addr_reg <= wr_addr_next;
        err_reg     <= err_next;
        printed_reg <= printed_next;
        pval_reg    <= pval_next;
        qneg_reg    <= qneg_next;
        aneg_reg    <= aneg_next;
        prod_reg    <= prod_next;
        if ((state_reg == rpn_pkg::S_DONE) && out_free)
        begin
            m_tdata_reg <= {5'd0, 8'(sp_reg), err_reg, pval_reg};
            m_tuser_reg <= printed_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== test/tb_top.sv =====
// Testbench for rpn_stack_calculator: directed and random token streams with
// a built-in Q16.16 stack predictor and an in-order result checker.
// Depends on rpn_pkg and the rpn_stack_calculator RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 128;
    localparam int NVARS = 26;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        printed;
        logic [31:0] value;
        logic [2:0]  err;
        logic [7:0]  depth;
    } calc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    logic signed [31:0] calc_stack [DEPTH];
    int                 calc_sp;
    logic signed [31:0] calc_vars [NVARS];
    logic signed [31:0] calc_last;
    bit                 calc_prev_var;
    int                 calc_prev_idx;
    logic [2:0]         calc_err;

    calc_result_t expected_results[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    bit  done = 1'b0;

    rpn_stack_calculator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    function automatic void raise(logic [2:0] code);
        if (calc_err == rpn_pkg::ERR_NONE)
            calc_err = code;
    endfunction

    function automatic void calc_push(logic signed [31:0] v);
        if (calc_sp < DEPTH)
        begin
            calc_stack[calc_sp] = v;
            calc_sp++;
        end
        else
            raise(rpn_pkg::ERR_FULL);
    endfunction

    function automatic logic signed [31:0] calc_pop();
        if (calc_sp > 0)
        begin
            calc_sp--;
            return calc_stack[calc_sp];
        end
        raise(rpn_pkg::ERR_EMPTY);
        return 0;
    endfunction

    function automatic logic signed [31:0] clamp(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF)
            return rpn_pkg::Q_MAX;
        if (v < -64'sh8000_0000)
            return rpn_pkg::Q_MIN;
        return v[31:0];
    endfunction

    function automatic calc_result_t evaluate(logic [3:0] mode, logic signed [31:0] num,
                                              logic [4:0] idx);
        calc_result_t r;
        logic signed [31:0] a, b;
        logic signed [63:0] wide;
        bit next_var;
        r = '0;
        next_var = 1'b0;
        calc_err = rpn_pkg::ERR_NONE;
        case (mode)
            rpn_pkg::MODE_NUM: calc_push(num);
            rpn_pkg::MODE_ADD, rpn_pkg::MODE_SUB, rpn_pkg::MODE_MUL, rpn_pkg::MODE_DIV,
            rpn_pkg::MODE_MOD:
            begin
                b = calc_pop();
                a = calc_pop();
                case (mode)
                    rpn_pkg::MODE_ADD: calc_push(clamp(64'(a) + 64'(b)));
                    rpn_pkg::MODE_SUB: calc_push(clamp(64'(a) - 64'(b)));
                    rpn_pkg::MODE_MUL:
                    begin
                        wide = 64'(a) * 64'(b);
                        calc_push(clamp(wide >>> 16));
                    end
                    rpn_pkg::MODE_DIV:
                        if (b == 0)
                        begin
                            raise(rpn_pkg::ERR_DIV0);
                            calc_push(a > 0 ? rpn_pkg::Q_MAX
                                            : (a < 0 ? rpn_pkg::Q_MIN : 32'sd0));
                        end
                        else
                            calc_push(clamp((64'(a) <<< 16) / 64'(b)));
                    default:
                        if (b == 0)
                        begin
                            raise(rpn_pkg::ERR_DIV0);
                            calc_push(a);
                        end
                        else
                            calc_push(32'(64'(a) % 64'(b)));
                endcase
            end
            rpn_pkg::MODE_PEEK:
            begin
                if (calc_sp > 0)
                    r.value = calc_stack[calc_sp-1];
                else
                    raise(rpn_pkg::ERR_EMPTY);
                r.printed = 1'b1;
                calc_last = r.value;
            end
            rpn_pkg::MODE_DUP:
                if (calc_sp == 0)
                    raise(rpn_pkg::ERR_EMPTY);
                else if (calc_sp >= DEPTH)
                    raise(rpn_pkg::ERR_FULL);
                else
                    calc_push(calc_stack[calc_sp-1]);
            rpn_pkg::MODE_SWAP:
                if (calc_sp < 2)
                    raise(rpn_pkg::ERR_SWAP);
                else
                begin
                    a = calc_stack[calc_sp-1];
                    calc_stack[calc_sp-1] = calc_stack[calc_sp-2];
                    calc_stack[calc_sp-2] = a;
                end
            rpn_pkg::MODE_CLEAR: calc_sp = 0;
            rpn_pkg::MODE_VAR:
                if (idx < NVARS)
                begin
                    calc_push(calc_vars[idx]);
                    next_var = 1'b1;
                end
                else
                    raise(rpn_pkg::ERR_NOT_VAR);
            rpn_pkg::MODE_ASSIGN:
            begin
                a = calc_pop();
                if (calc_prev_var && calc_prev_idx < NVARS)
                    calc_vars[calc_prev_idx] = calc_pop();
                else
                    raise(rpn_pkg::ERR_NOT_VAR);
            end
            rpn_pkg::MODE_LAST: calc_push(calc_last);
            rpn_pkg::MODE_EOL:
            begin
                r.value = calc_pop();
                r.printed = 1'b1;
                calc_last = r.value;
            end
            default: raise(rpn_pkg::ERR_NOT_VAR);
        endcase
        calc_prev_var = next_var;
        calc_prev_idx = idx;
        r.err = calc_err;
        r.depth = calc_sp[7:0];
        return r;
    endfunction

    task automatic send_token(logic [3:0] mode, logic signed [31:0] num = 0,
                              logic [4:0] idx = 0);
        while (!steady && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {3'b000, idx, num};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(evaluate(mode, num, idx));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return $urandom;
            1: return rpn_pkg::Q_MAX;
            2: return rpn_pkg::Q_MIN;
            3: return 0;
            default: return $signed($urandom_range(20 << 16)) - (10 << 16);
        endcase
    endfunction

    task automatic test_directed();
        logic [3:0] m;
        send_token(rpn_pkg::MODE_EOL);
        send_token(rpn_pkg::MODE_PEEK);
        send_token(rpn_pkg::MODE_SWAP);
        send_token(rpn_pkg::MODE_DUP);
        send_token(rpn_pkg::MODE_ASSIGN);
        send_token(rpn_pkg::MODE_NUM, rpn_pkg::Q_MAX);
        send_token(rpn_pkg::MODE_NUM, rpn_pkg::Q_MAX);
        send_token(rpn_pkg::MODE_ADD);
        send_token(rpn_pkg::MODE_NUM, rpn_pkg::Q_MIN);
        send_token(rpn_pkg::MODE_MUL);
        send_token(rpn_pkg::MODE_NUM, 0);
        send_token(rpn_pkg::MODE_DIV);
        send_token(rpn_pkg::MODE_NUM, 32'sh0003_8000);
        send_token(rpn_pkg::MODE_NUM, 0);
        send_token(rpn_pkg::MODE_MOD);
        send_token(rpn_pkg::MODE_VAR, 0, 5'd31);
        send_token(rpn_pkg::MODE_VAR, 0, 5'd25);
        send_token(rpn_pkg::MODE_NUM, 32'sh0002_0000);
        send_token(rpn_pkg::MODE_ASSIGN);
        send_token(rpn_pkg::MODE_SWAP);
        send_token(rpn_pkg::MODE_EOL);
        send_token(rpn_pkg::MODE_LAST);
        m = 4'd14;
        send_token(m);
        m = 4'd15;
        send_token(m);
        send_token(rpn_pkg::MODE_CLEAR);
    endtask

    task automatic test_full_stack();
        steady = 1'b1;
        for (int i = 0; i < DEPTH + 1; i++)
            send_token(rpn_pkg::MODE_NUM, $urandom);
        send_token(rpn_pkg::MODE_DUP);
        send_token(rpn_pkg::MODE_LAST);
        send_token(rpn_pkg::MODE_SWAP);
        send_token(rpn_pkg::MODE_CLEAR);
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 12; i++)
            send_token(rpn_pkg::MODE_NUM, rand_q());
        wait_drained();
        send_token(rpn_pkg::MODE_CLEAR);
    endtask

    task automatic test_random(int count);
        logic [3:0] m;
        for (int i = 0; i < count; i++)
        begin
            steady = (i >= count / 2) && (i < count / 2 + 150);
            case ($urandom_range(9))
                0, 1:
                begin
                    send_token(rpn_pkg::MODE_NUM, rand_q());
                    send_token(rpn_pkg::MODE_NUM, rand_q());
                    m = 4'($urandom_range(rpn_pkg::MODE_ADD, rpn_pkg::MODE_MOD));
                    send_token(m);
                    send_token(rpn_pkg::MODE_EOL);
                end
                2:
                begin
                    send_token(rpn_pkg::MODE_NUM, rand_q());
                    send_token(rpn_pkg::MODE_VAR, 0, 5'($urandom_range(NVARS - 1)));
                    send_token(rpn_pkg::MODE_ASSIGN);
                end
                3:
                begin
                    send_token(rpn_pkg::MODE_VAR, 0, 5'($urandom_range(NVARS - 1)));
                    send_token(rpn_pkg::MODE_LAST);
                    send_token(rpn_pkg::MODE_MUL);
                end
                4:
                    send_token(4'($urandom_range(15)), rand_q(), 5'($urandom));
                default:
                begin
                    if (calc_sp >= 100)
                        m = rpn_pkg::MODE_CLEAR;
                    else
                        m = 4'($urandom_range(rpn_pkg::MODE_EOL));
                    send_token(m, rand_q(), 5'($urandom_range(NVARS - 1)));
                end
            endcase
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || $urandom_range(99) >= 16;
        end
    end

    always @(posedge clk)
    begin
        calc_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tdata[31:0], m_tdata[34:32], m_tdata[42:35]};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: exp printed=%b val=%h err=%0d depth=%0d, ",
                                  "got printed=%b val=%h err=%0d depth=%0d"},
                                 results_seen, want.printed, want.value, want.err,
                                 want.depth, got.printed, got.value, got.err, got.depth);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        calc_sp = 0;
        calc_last = 0;
        calc_prev_var = 1'b0;
        calc_prev_idx = 0;
        foreach (calc_vars[i])
            calc_vars[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_stack();
        test_backpressure();
        test_random(565);
        wait_drained();
        repeat (100) @(posedge clk);
        done = 1'b1;
        $display("Sent %0d tokens covering every mode, stack limits, variables and stalls;",
                 items_sent);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_div.sv
sv/rpn_stack_calculator.sv
test/tb_top.sv
